[hw/rtl/iat_pkg.sv]
// Shared types and codes for the idle entry aging table.
package iat_pkg;

	localparam int unsigned TimeW   = 48;
	localparam int unsigned TotalW  = 48;
	localparam int unsigned ActiveW = 32;
	localparam int unsigned TmoW    = 32;
	localparam int unsigned IndexW  = 6;
	localparam int unsigned MaxReach = 64;

	localparam logic [1:0] ACT_DISCOVER = 2'd0;
	localparam logic [1:0] ACT_REMOVE   = 2'd1;
	localparam logic [1:0] ACT_SAMPLE   = 2'd2;

	typedef enum logic [2:0] {
		VERDICT_NONE    = 3'd0,
		VERDICT_ACTIVE  = 3'd1,
		VERDICT_IDLE    = 3'd2,
		VERDICT_DROPPED = 3'd3,
		VERDICT_RECLAIM = 3'd4
	} verdict_t;

	typedef struct packed {
		logic [TotalW-1:0] baseline_total;
		logic [TimeW-1:0]  last_active_time;
	} entry_data_t;

endpackage

[hw/rtl/iat_entry_ram.sv]
// Entry data memory with registered read and write-to-read bypass.
module iat_entry_ram #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6
) (
	input  logic                clk,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  iat_pkg::entry_data_t wr_data,
	output iat_pkg::entry_data_t rd_data
);

	iat_pkg::entry_data_t mem [DEPTH];
	iat_pkg::entry_data_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data_q <= wr_data;
			end else begin
				rd_data_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hw/rtl/idle_entry_aging_table.sv]
// Top level of the idle entry aging table.
// The table tracks entries by index. Each accepted item (discover, remove or
// sample) produces exactly one result item, whose verdict tells whether the
// entry is active, idle but kept, dropped as absent or reclaimed after the
// inactivity timeout, and whether any entry is still tracked. One item is
// accepted every cycle while the output does not stall; results are
// registered. The rate is set by the entry memory, which does one read and one
// write per cycle, with a bypass when consecutive items hit the same entry.
// Valid marks are cleared by reset at once, so no clearing pass is needed.
// The timeout register may be written only while the table is idle.
module idle_entry_aging_table #(
	parameter int unsigned ENTRIES = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [iat_pkg::TmoW-1:0]       cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     action,
	input  logic [iat_pkg::IndexW-1:0]     entry_index,
	input  logic [iat_pkg::TimeW-1:0]      now_ms,
	input  logic                           sample_present,
	input  logic [iat_pkg::ActiveW-1:0]    active_requests,
	input  logic [iat_pkg::TotalW-1:0]     total_requests,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [iat_pkg::IndexW-1:0]     entry_number,
	output logic [2:0]                     verdict,
	output logic                           any_tracked
);

	localparam int unsigned DEPTH = (ENTRIES < iat_pkg::MaxReach) ? ENTRIES : iat_pkg::MaxReach;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW    = $clog2(DEPTH + 1);

	logic [iat_pkg::TmoW-1:0]    timeout_q;

	logic                         valid_s1;
	logic [1:0]                   action_s1;
	logic [iat_pkg::IndexW-1:0]   idx_s1;
	logic [iat_pkg::TimeW-1:0]    now_s1;
	logic                         present_s1;
	logic [iat_pkg::ActiveW-1:0]  active_s1;
	logic [iat_pkg::TotalW-1:0]   total_s1;

	logic [DEPTH-1:0]             valid_q;
	logic [CW-1:0]                count_q;

	logic                         out_valid_q;
	logic [iat_pkg::IndexW-1:0]   entry_number_q;
	iat_pkg::verdict_t            verdict_q;
	logic                         any_tracked_q;

	logic                         accept;
	logic                         s1_adv;
	logic [AW-1:0]                addr_s1;
	logic                         in_range_s1;
	logic                         ent_valid;
	iat_pkg::entry_data_t         rd_data;
	iat_pkg::entry_data_t         wr_data;
	logic                         wr_en;
	logic                         set_valid;
	logic                         clr_valid;
	logic [iat_pkg::TimeW-1:0]    idle_ms;
	logic                         was_active;
	iat_pkg::verdict_t            verdict_d;
	logic [CW-1:0]                count_d;

	assign cfg_ready = 1'b1;
	assign s1_adv    = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || s1_adv;
	assign accept    = in_valid && in_ready;

	assign addr_s1     = idx_s1[AW-1:0];
	assign in_range_s1 = ({{(32 - iat_pkg::IndexW){1'b0}}, idx_s1} < 32'(DEPTH));
	assign ent_valid   = valid_q[addr_s1];
	assign idle_ms     = now_s1 - rd_data.last_active_time;
	assign was_active  = (active_s1 != '0) || (total_s1 != rd_data.baseline_total);

	iat_entry_ram #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ram (
		.clk    (clk),
		.rd_en  (accept),
		.rd_addr(entry_index[AW-1:0]),
		.wr_en  (wr_en && s1_adv),
		.wr_addr(addr_s1),
		.wr_data(wr_data),
		.rd_data(rd_data)
	);

	always_comb begin
		wr_en     = 1'b0;
		set_valid = 1'b0;
		clr_valid = 1'b0;
		verdict_d = iat_pkg::VERDICT_NONE;
		wr_data   = rd_data;
		if (in_range_s1) begin
			unique case (action_s1)
				iat_pkg::ACT_DISCOVER: begin
					if (timeout_q != '0) begin
						set_valid = 1'b1;
						wr_en     = 1'b1;
						wr_data.baseline_total   = present_s1 ? total_s1 : '0;
						wr_data.last_active_time = now_s1;
					end
				end
				iat_pkg::ACT_REMOVE: begin
					clr_valid = 1'b1;
				end
				iat_pkg::ACT_SAMPLE: begin
					if (ent_valid) begin
						if (!present_s1) begin
							clr_valid = 1'b1;
							verdict_d = iat_pkg::VERDICT_DROPPED;
						end else begin
							wr_en = 1'b1;
							wr_data.baseline_total = total_s1;
							if (was_active) begin
								wr_data.last_active_time = now_s1;
								verdict_d = iat_pkg::VERDICT_ACTIVE;
							end else if (idle_ms >= {{(iat_pkg::TimeW - iat_pkg::TmoW){1'b0}},
									timeout_q}) begin
								clr_valid = 1'b1;
								verdict_d = iat_pkg::VERDICT_RECLAIM;
							end else begin
								verdict_d = iat_pkg::VERDICT_IDLE;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		count_d = count_q;
		if (set_valid && !ent_valid) begin
			count_d = count_q + CW'(1);
		end else if (clr_valid && ent_valid) begin
			count_d = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= '0;
			valid_s1    <= 1'b0;
			valid_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				timeout_q <= cfg_data;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
				count_q     <= count_d;
				if (set_valid) begin
					valid_q[addr_s1] <= 1'b1;
				end else if (clr_valid) begin
					valid_q[addr_s1] <= 1'b0;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1  <= action;
			idx_s1     <= entry_index;
			now_s1     <= now_ms;
			present_s1 <= sample_present;
			active_s1  <= active_requests;
			total_s1   <= total_requests;
		end
		if (s1_adv) begin
			entry_number_q <= idx_s1;
			verdict_q      <= verdict_d;
			any_tracked_q  <= (count_d != '0);
		end
	end

	assign out_valid    = out_valid_q;
	assign entry_number = entry_number_q;
	assign verdict      = verdict_q;
	assign any_tracked  = any_tracked_q;

`ifndef SYNTHESIS
	// The tracked count always matches the number of valid marks.
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(count_q))
		else $error("tracked count differs from valid marks");

	// An active verdict implies at least one entry is still tracked.
	a_active_tracked: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (verdict_q == iat_pkg::VERDICT_ACTIVE)) |-> any_tracked_q)
		else $error("active verdict with no tracked entry");

	// With no result waiting the block always takes a new item.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty output");
`endif

endmodule
